FILE: rtl/b64e_pkg.sv
`timescale 1ns / 1ps
package b64e_pkg;

  // Characters that sit outside the alphabet's letter and digit runs, and the first character of each run
  localparam logic [6:0] PAD_CHAR   = 7'h3D;  // '='
  localparam logic [6:0] PLUS_CHAR  = 7'h2B;  // '+'
  localparam logic [6:0] SLASH_CHAR = 7'h2F;  // '/'
  localparam logic [6:0] UPPER_A    = 7'h41;  // 'A'
  localparam logic [6:0] LOWER_A    = 7'h61;  // 'a'
  localparam logic [6:0] DIGIT_0    = 7'h30;  // '0'

  // Entries in the request queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // One output symbol: a sextet or a pad marker
  typedef struct packed {
    logic       pad;
    logic [5:0] val;
  } sym_t;

  // One request for the back end: up to four symbols
  typedef struct packed {
    sym_t [3:0] sym;
    logic [1:0] last_idx;  // index of the final symbol (count - 1)
    logic       last;      // final symbol closes the message
  } job_t;

  // Sextet to ASCII, standard alphabet
  function automatic logic [6:0] sextet_char(input logic [5:0] v);
    logic [6:0] w;
    logic [6:0] c;
    w = {1'b0, v};
    if (v < 6'd26) begin
      c = UPPER_A + w;
    end else if (v < 6'd52) begin
      c = LOWER_A + (w - 7'd26);
    end else if (v < 6'd62) begin
      c = DIGIT_0 + (w - 7'd52);
    end else if (v == 6'd62) begin
      c = PLUS_CHAR;
    end else begin
      c = SLASH_CHAR;
    end
    return c;
  endfunction

endpackage

FILE: rtl/b64e_front.sv
`timescale 1ns / 1ps
module b64e_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data_byte,
  input  logic              in_last_byte,
  input  logic              q_full,
  output logic              q_push,
  output b64e_pkg::job_t    q_job
);

  typedef enum logic [1:0] {
    PH_0 = 2'd0,
    PH_1 = 2'd1,
    PH_2 = 2'd2
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [3:0] carry_r, carry_nxt;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // Split the byte into sextets by group phase
  always_comb begin
    phase_nxt = phase_r;
    carry_nxt = carry_r;
    q_job     = '0;
    unique case (phase_r)
      PH_1: begin
        q_job.sym[0].val = {carry_r[1:0], in_data_byte[7:4]};
        if (in_last_byte) begin
          q_job.sym[1].val = {in_data_byte[3:0], 2'b00};
          q_job.sym[2].pad = 1'b1;
          q_job.last_idx   = 2'd2;
          q_job.last       = 1'b1;
          phase_nxt        = PH_0;
          carry_nxt        = 4'd0;
        end else begin
          q_job.last_idx = 2'd0;
          phase_nxt      = PH_2;
          carry_nxt      = in_data_byte[3:0];
        end
      end
      PH_2: begin
        q_job.sym[0].val = {carry_r, in_data_byte[7:6]};
        q_job.sym[1].val = in_data_byte[5:0];
        q_job.last_idx   = 2'd1;
        q_job.last       = in_last_byte;
        phase_nxt        = PH_0;
        carry_nxt        = 4'd0;
      end
      default: begin
        // Start of a group; the unused phase code lands here too
        q_job.sym[0].val = in_data_byte[7:2];
        if (in_last_byte) begin
          q_job.sym[1].val = {in_data_byte[1:0], 4'b0000};
          q_job.sym[2].pad = 1'b1;
          q_job.sym[3].pad = 1'b1;
          q_job.last_idx   = 2'd3;
          q_job.last       = 1'b1;
          phase_nxt        = PH_0;
          carry_nxt        = 4'd0;
        end else begin
          q_job.last_idx = 2'd0;
          phase_nxt      = PH_1;
          carry_nxt      = {2'b00, in_data_byte[1:0]};
        end
      end
    endcase
  end

  // Group state advances on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_0;
      carry_r <= 4'd0;
    end else if (q_push) begin
      phase_r <= phase_nxt;
      carry_r <= carry_nxt;
    end
  end

endmodule

FILE: rtl/b64e_queue.sv
`timescale 1ns / 1ps
module b64e_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  b64e_pkg::job_t    push_job,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output b64e_pkg::job_t    head_job
);

  localparam int PW = (b64e_pkg::QUEUE_DEPTH > 1) ? $clog2(b64e_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(b64e_pkg::QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(b64e_pkg::QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(b64e_pkg::QUEUE_DEPTH);

  b64e_pkg::job_t mem_r [b64e_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  cnt_r;

  assign full       = (cnt_r == FULL_CNT);
  assign head_valid = (cnt_r != '0);
  assign head_job   = mem_r[rd_ptr_r];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("request queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !head_valid))
    else $error("request queue popped while empty");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("request queue count out of range");
`endif

endmodule

FILE: rtl/b64e_back.sv
`timescale 1ns / 1ps
module b64e_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  b64e_pkg::job_t    head_job,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [6:0]        out_char,
  output logic              out_last_char
);

  logic [1:0]     idx_r, idx_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [6:0]     out_char_r;
  logic           out_last_r;
  logic           adv, emit, final_sym;
  b64e_pkg::sym_t cur_sym;
  logic [6:0]     cur_char;

  // Output register free or being drained this cycle
  assign adv       = !out_valid_r || out_ready;
  assign emit      = adv && head_valid;
  assign final_sym = (idx_r == head_job.last_idx);
  assign pop       = emit && final_sym;

  // Pick the current symbol and map it to ASCII
  always_comb begin
    cur_sym  = head_job.sym[idx_r];
    cur_char = cur_sym.pad ? b64e_pkg::PAD_CHAR : b64e_pkg::sextet_char(cur_sym.val);
  end

  // Symbol index and output valid
  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (emit) begin
      idx_nxt       = final_sym ? 2'd0 : idx_r + 2'd1;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_char_r <= cur_char;
      out_last_r <= final_sym && head_job.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char      = out_char_r;
  assign out_last_char = out_last_r;

`ifndef SYNTHESIS
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> (idx_r <= head_job.last_idx))
    else $error("symbol index past end of request");

  a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !head_valid |-> (idx_r == 2'd0))
    else $error("symbol index left mid-request with queue empty");

  a_last_pops: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && head_job.last && final_sym) |=> (out_valid_r && out_last_r))
    else $error("message end not flagged on output");
`endif

endmodule

FILE: rtl/base64_stream_encoder.sv
`timescale 1ns / 1ps
// The byte's request is written into the queue, and its first character is then registered at the output.
// Characters leave at one per cycle while out_ready is high and a request is queued; a byte
// yields 1 to 4 characters (1 mid-group, 2 closing a group, 3 or 4 with padding).
// A two-entry request queue lets the input run ahead while characters drain.
// Reset (rst_n low, synchronous) empties the queue and returns to the start of a group.
module base64_stream_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_char,
  output logic       out_last_char
);

  logic           q_full, q_push, q_pop, q_head_valid;
  b64e_pkg::job_t q_job, q_head;

  b64e_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (q_job)
  );

  b64e_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head)
  );

  b64e_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (q_head_valid),
    .head_job      (q_head),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char      (out_char),
    .out_last_char (out_last_char)
  );

endmodule
